// ===== sv/smlf_pkg.sv =====
// Shared types and constants of the sliding median line filter.
package smlf_pkg;

   localparam int WINDOW_SIZE_DEF = 30;
   localparam int LINE_LENGTH_DEF = 128;
   localparam int SAMPLE_W = 8;
   localparam int POS_W = 7;
   localparam int RUN_W = 7;
   localparam int SLOT_W = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SLOT_W-1:0]   slot;
      logic                line_start;
      logic                do_remove;
      logic                do_emit;
      logic [POS_W-1:0]    start_pos;
      logic [RUN_W-1:0]    run_len;
   } smlf_job_type;

   typedef struct packed {
      logic         valid;
      smlf_job_type job;
   } smlf_q_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_REMOVE,
      BK_INSERT,
      BK_MEDIAN,
      BK_EMIT
   } smlf_back_state_type;

endpackage

// ===== sv/smlf_front.sv =====
// Front end: accepts pixels, tracks line position and ring slot, and builds one job per pixel.
module smlf_front #(
   parameter int WINDOW_SIZE = smlf_pkg::WINDOW_SIZE_DEF,
   parameter int LINE_LENGTH = smlf_pkg::LINE_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [smlf_pkg::SAMPLE_W-1:0] req_tdata,
   output logic                          push,
   input  logic                          push_ready,
   output smlf_pkg::smlf_job_type        push_job
);
   import smlf_pkg::*;

   localparam int PW = $clog2(LINE_LENGTH);
   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int HALF = WINDOW_SIZE / 2;

   logic [PW-1:0] pixel_count_ff, pixel_count_in;
   logic [AW-1:0] oldest_slot_ff, oldest_slot_in;
   logic          is_first;
   logic          is_last;

   assign req_tready = push_ready;
   assign push       = req_tvalid && push_ready;

   assign is_first = (pixel_count_ff == PW'(WINDOW_SIZE - 1));
   assign is_last  = (pixel_count_ff == PW'(LINE_LENGTH - 1));

   always_comb begin
      push_job.sample     = req_tdata;
      push_job.slot       = SLOT_W'(oldest_slot_ff);
      push_job.line_start = (pixel_count_ff == '0);
      push_job.do_remove  = (int'(pixel_count_ff) >= WINDOW_SIZE);
      push_job.do_emit    = (pixel_count_ff >= PW'(WINDOW_SIZE - 1));
      push_job.start_pos  = is_first ? '0 : (POS_W'(pixel_count_ff) - POS_W'(HALF));
      push_job.run_len    = (is_first ? RUN_W'(WINDOW_SIZE - HALF) : RUN_W'(1))
                          + (is_last ? RUN_W'(HALF) : RUN_W'(0));
   end

   always_comb begin
      pixel_count_in = pixel_count_ff;
      oldest_slot_in = oldest_slot_ff;
      if (push) begin
         pixel_count_in = is_last ? '0 : pixel_count_ff + PW'(1);
         oldest_slot_in = (oldest_slot_ff == AW'(WINDOW_SIZE - 1)) ? '0
                        : oldest_slot_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= '0;
         oldest_slot_ff <= '0;
      end else begin
         pixel_count_ff <= pixel_count_in;
         oldest_slot_ff <= oldest_slot_in;
      end
   end

endmodule

// ===== sv/smlf_queue.sv =====
// Short job queue between the front end and the back end.
module smlf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   push_ready,
   input  smlf_pkg::smlf_job_type push_job,
   input  logic                   pop,
   output smlf_pkg::smlf_q_type   head
);
   import smlf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   smlf_job_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/smlf_back.sv =====
// Back end: sample ring, sorted window cells, median and result beat sequencer.
module smlf_back #(
   parameter int WINDOW_SIZE = smlf_pkg::WINDOW_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  smlf_pkg::smlf_q_type            head,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smlf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import smlf_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int CW = $clog2(WINDOW_SIZE + 1);
   localparam int HALF = WINDOW_SIZE / 2;
   localparam bit ODD = (WINDOW_SIZE % 2) == 1;

   smlf_back_state_type state_ff, state_in;
   smlf_job_type        job_ff;
   logic [SAMPLE_W-1:0] ring_mem [WINDOW_SIZE];
   logic [SAMPLE_W-1:0] oldest_ff;
   logic [SAMPLE_W-1:0] cell_ff [WINDOW_SIZE];
   logic [SAMPLE_W-1:0] cell_in [WINDOW_SIZE];
   logic [CW-1:0]       count_ff, count_in;
   logic [SAMPLE_W-1:0] median_ff, median_in;
   logic [POS_W-1:0]    pos_ff;
   logic [RUN_W-1:0]    left_ff;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [SAMPLE_W-1:0] rsp_median_ff;
   logic [POS_W-1:0]    rsp_index_ff;
   logic                rsp_last_ff;
   logic                load_beat;
   logic                below_old [WINDOW_SIZE];
   logic                at_most_new [WINDOW_SIZE];
   logic [SAMPLE_W:0]   mid_sum;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_index_ff, rsp_median_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               state_in = head.job.do_remove ? BK_REMOVE : BK_INSERT;
            end
         end
         BK_REMOVE: begin
            state_in = BK_INSERT;
         end
         BK_INSERT: begin
            state_in = job_ff.do_emit ? BK_MEDIAN : BK_IDLE;
         end
         BK_MEDIAN: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (load_beat && left_ff == RUN_W'(1)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop       = (state_ff == BK_IDLE) && head.valid;
      load_beat = (state_ff == BK_EMIT) && (!rsp_tvalid_ff || rsp_tready);
      rsp_tvalid_in = rsp_tvalid_ff;
      if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tvalid_in = load_beat;
      end
      count_in = count_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && head.job.line_start) begin
               count_in = '0;
            end
         end
         BK_REMOVE: begin
            count_in = count_ff - CW'(1);
         end
         BK_INSERT: begin
            count_in = count_ff + CW'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         below_old[k]   = cell_ff[k] < oldest_ff;
         at_most_new[k] = (CW'(k) < count_ff) && (cell_ff[k] <= job_ff.sample);
      end
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         cell_in[k] = cell_ff[k];
      end
      if (state_ff == BK_REMOVE) begin
         for (int k = 0; k < WINDOW_SIZE - 1; k++) begin
            cell_in[k] = below_old[k] ? cell_ff[k] : cell_ff[k+1];
         end
      end else if (state_ff == BK_INSERT) begin
         cell_in[0] = at_most_new[0] ? cell_ff[0] : job_ff.sample;
         for (int k = 1; k < WINDOW_SIZE; k++) begin
            cell_in[k] = at_most_new[k]   ? cell_ff[k]
                       : at_most_new[k-1] ? job_ff.sample
                       : cell_ff[k-1];
         end
      end
   end

   always_comb begin
      mid_sum = {1'b0, cell_ff[HALF-1]} + {1'b0, cell_ff[HALF]};
      if (ODD) begin
         median_in = cell_ff[HALF];
      end else begin
         median_in = mid_sum[SAMPLE_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ring_mem[head.job.slot[AW-1:0]] <= head.job.sample;
         oldest_ff <= ring_mem[head.job.slot[AW-1:0]];
         job_ff    <= head.job;
      end
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         cell_ff[k] <= cell_in[k];
      end
      if (state_ff == BK_MEDIAN) begin
         median_ff <= median_in;
         pos_ff    <= job_ff.start_pos;
         left_ff   <= job_ff.run_len;
      end else if (load_beat) begin
         pos_ff  <= pos_ff + POS_W'(1);
         left_ff <= left_ff - RUN_W'(1);
      end
      if (load_beat) begin
         rsp_median_ff <= median_ff;
         rsp_index_ff  <= pos_ff;
         rsp_last_ff   <= (left_ff == RUN_W'(1));
      end
   end

endmodule

// ===== sv/sliding_median_line_filter_top.sv =====
// Top level of the sliding median line filter.
// Pixels of a sensor line enter one beat at a time; the block keeps the last WINDOW_SIZE of
// them and, once the window is full, returns its median (even windows average the two middle
// values, truncated), tagged with the line position it belongs to and with tlast on the last
// result beat caused by a pixel. The first full window repeats its median over the leading
// positions and the last pixel of a line repeats the final median over the trailing positions.
// A pixel that displaces an old sample passes the back end through three steps (ring read and
// write, then sorted-cell removal, then insertion); while the window fills there is no removal
// and a pixel takes only the ring step and insertion. A pixel with results adds a median step,
// then one result beat per cycle while the result side is ready; a two-entry job queue lets the
// front end keep accepting pixels meanwhile, until the queue is full. The ring needs no clearing
// pass after reset.
module sliding_median_line_filter_top #(
   parameter int WINDOW_SIZE = smlf_pkg::WINDOW_SIZE_DEF,
   parameter int LINE_LENGTH = smlf_pkg::LINE_LENGTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [smlf_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smlf_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] median, [14:8] pixel_index
   output logic                            rsp_tlast
);
   import smlf_pkg::*;

   logic         push;
   logic         push_ready;
   smlf_job_type push_job;
   logic         pop;
   smlf_q_type   head;

   smlf_front #(
      .WINDOW_SIZE(WINDOW_SIZE),
      .LINE_LENGTH(LINE_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   smlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop        (pop),
      .head       (head)
   );

   smlf_back #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/smlf_checker.sv =====
// Port-level checks of the sliding median line filter and their binding to the top level.
module smlf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [smlf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15] == 1'b0)
      else $error("result pad bit set");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid
         && rsp_tdata[7:0] == $past(rsp_tdata[7:0])
         && rsp_tdata[14:8] == $past(rsp_tdata[14:8]) + 7'd1)
      else $error("run of result beats broken");

endmodule

bind sliding_median_line_filter_top smlf_checker u_smlf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
